### src/tjps_pkg.sv
// shared types, constants and tables for the tagged jet pair momentum selector
package tjps_pkg;

    localparam int NUM_WP      = 6;
    localparam int WP_IDX_W    = $clog2(NUM_WP);
    localparam int MAX_JETS    = 64;
    localparam int CNT_W       = $clog2(MAX_JETS + 1);
    localparam int JET_IDX_W   = $clog2(MAX_JETS);
    localparam int NUM_RESULTS = 27;
    localparam int COMBO_W     = 5;
    localparam int MOM_W       = 16;
    localparam int SCORE_W     = 16;
    localparam int RAP_W       = 16;
    localparam int LIMIT_W     = 10;
    localparam int TALLY_W     = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item kinds
    localparam logic [1:0] KIND_JET       = 2'd0;
    localparam logic [1:0] KIND_JET_END   = 2'd1;
    localparam logic [1:0] KIND_EMPTY_END = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIRST_LOOSE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_MEDIUM  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_TIGHT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_LOOSE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_MEDIUM = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_TIGHT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RAPIDITY_LIM  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MOM_CEILING   = 3'd7;

    localparam logic [TALLY_W-1:0] TALLY_NONE = 2'd0;
    localparam logic [TALLY_W-1:0] TALLY_ONE  = 2'd1;
    localparam logic [TALLY_W-1:0] TALLY_TWO  = 2'd2;

    typedef logic signed [SCORE_W-1:0] cut_t;
    typedef cut_t [NUM_WP-1:0] cut_arr_t;

    localparam cut_t CUT_RESET [NUM_WP] = '{
        16'sd170, 16'sd330, 16'sd1020, 16'sd119, 16'sd193, 16'sd341
    };
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 10'd300;
    localparam logic [MOM_W-1:0]   CEILING_RESET = 16'd3198;

    typedef struct packed {
        logic [MOM_W-1:0]     leader_momentum;
        logic [JET_IDX_W-1:0] leader_jet;
        logic [MOM_W-1:0]     runner_momentum;
        logic [TALLY_W-1:0]   pass_tally;
    } wp_entry_t;

    typedef struct packed {
        wp_entry_t [NUM_WP-1:0] wp;
    } event_summary_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

    typedef struct packed {
        logic [WP_IDX_W-1:0] a;
        logic [WP_IDX_W-1:0] b;
    } wp_pair_t;

    // working points looked at for each result; singles use a alone
    localparam wp_pair_t PAIR_TABLE [NUM_RESULTS] = '{
        '{3'd0, 3'd0}, '{3'd1, 3'd1}, '{3'd2, 3'd2},
        '{3'd3, 3'd3}, '{3'd4, 3'd4}, '{3'd5, 3'd5},
        '{3'd0, 3'd0}, '{3'd0, 3'd1}, '{3'd0, 3'd2},
        '{3'd0, 3'd3}, '{3'd0, 3'd4}, '{3'd0, 3'd5},
        '{3'd1, 3'd1}, '{3'd1, 3'd2}, '{3'd1, 3'd3},
        '{3'd1, 3'd4}, '{3'd1, 3'd5},
        '{3'd2, 3'd2}, '{3'd2, 3'd3}, '{3'd2, 3'd4},
        '{3'd2, 3'd5},
        '{3'd3, 3'd3}, '{3'd3, 3'd4}, '{3'd3, 3'd5},
        '{3'd4, 3'd4}, '{3'd4, 3'd5},
        '{3'd5, 3'd5}
    };

    function automatic logic [MOM_W-1:0] umin(input logic [MOM_W-1:0] x,
                                              input logic [MOM_W-1:0] y);
        return (x < y) ? x : y;
    endfunction

endpackage

### src/tjps_if.sv
// item channels: jets in, results out
interface tjps_jet_if
    import tjps_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [MOM_W-1:0]    momentum;
    logic signed [RAP_W-1:0]   rapidity;
    logic signed [SCORE_W-1:0] first_score;
    logic signed [SCORE_W-1:0] second_score;

    modport source (output valid, kind, momentum, rapidity, first_score, second_score,
                    input ready);
    modport sink (input valid, kind, momentum, rapidity, first_score, second_score,
                  output ready);
endinterface

interface tjps_result_if
    import tjps_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [COMBO_W-1:0] combo;
    logic [MOM_W-1:0]   selected_momentum;
    logic               last;

    modport source (output valid, combo, selected_momentum, last, input ready);
    modport sink (input valid, combo, selected_momentum, last, output ready);
endinterface

### src/tjps_front.sv
// front end: takes jets, keeps per working point leaders, hands off event summaries
module tjps_front
    import tjps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tjps_jet_if.sink            jets,
    input  cut_arr_t            cuts,
    input  logic [LIMIT_W-1:0]  limit,
    input  queue_status_t       queue_status,
    output logic                push,
    output event_summary_t      summary
);

    event_summary_t   acc_reg;
    event_summary_t   acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             take;
    logic             in_range;
    logic [RAP_W-1:0] abs_rap;
    logic             accept;
    logic             ends_event;

    assign jets.ready = !queue_status.full;
    assign accept     = jets.valid && jets.ready;
    assign ends_event = (jets.kind != KIND_JET);
    assign push       = accept && ends_event;
    assign summary    = acc_next;

    always_comb
    begin
        logic signed [SCORE_W-1:0] score;
        wp_entry_t                 e;
        take     = ((jets.kind == KIND_JET) || (jets.kind == KIND_JET_END))
                   && (cnt_reg < CNT_W'(MAX_JETS));
        abs_rap  = jets.rapidity[RAP_W-1] ? RAP_W'(~jets.rapidity + 1'b1)
                                          : RAP_W'(jets.rapidity);
        in_range = (abs_rap <= {{(RAP_W-LIMIT_W){1'b0}}, limit});
        cnt_next = take ? cnt_reg + 1'b1 : cnt_reg;
        acc_next = acc_reg;
        for (int i = 0; i < NUM_WP; i++)
        begin
            score = (i < NUM_WP / 2) ? jets.first_score : jets.second_score;
            e     = acc_reg.wp[i];
            if (take && in_range && (score > cuts[i]))
            begin
                if (e.pass_tally == TALLY_NONE)
                begin
                    e.leader_momentum = jets.momentum;
                    e.leader_jet      = cnt_reg[JET_IDX_W-1:0];
                    e.pass_tally      = TALLY_ONE;
                end
                else if (jets.momentum > e.leader_momentum)
                begin
                    e.runner_momentum = e.leader_momentum;
                    e.leader_momentum = jets.momentum;
                    e.leader_jet      = cnt_reg[JET_IDX_W-1:0];
                    e.pass_tally      = TALLY_TWO;
                end
                else
                begin
                    // ties stay behind the earlier leader
                    if ((e.pass_tally == TALLY_ONE) || (jets.momentum > e.runner_momentum))
                    begin
                        e.runner_momentum = jets.momentum;
                    end
                    e.pass_tally = TALLY_TWO;
                end
            end
            acc_next.wp[i] = e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (ends_event)
            begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

### src/tjps_queue.sv
// short queue of finished event summaries between front and back
module tjps_queue
    import tjps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  event_summary_t  push_data,
    input  logic            pop,
    output event_summary_t  head,
    output queue_status_t   status
);

    event_summary_t    mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head              = mem[rd_ptr_reg];
    assign status.full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.head_valid = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/tjps_back.sv
// back end: walks the 27 results of the head event into the output register
module tjps_back
    import tjps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  event_summary_t     head,
    input  queue_status_t      queue_status,
    input  logic [MOM_W-1:0]   ceiling,
    output logic               pop,
    tjps_result_if.source      results
);

    logic [COMBO_W-1:0] combo_reg;
    logic [COMBO_W-1:0] combo_next;
    logic               out_valid_reg;
    logic [COMBO_W-1:0] out_combo_reg;
    logic [MOM_W-1:0]   out_mom_reg;
    logic               out_last_reg;
    logic               load;
    logic               advance;
    logic               final_combo;
    wp_pair_t           pair;
    wp_entry_t          ea;
    wp_entry_t          eb;
    logic [MOM_W-1:0]   value;

    assign results.valid             = out_valid_reg;
    assign results.combo             = out_combo_reg;
    assign results.selected_momentum = out_mom_reg;
    assign results.last              = out_last_reg;

    assign load        = !out_valid_reg || results.ready;
    assign advance     = load && queue_status.head_valid;
    assign final_combo = (combo_reg == COMBO_W'(NUM_RESULTS - 1));
    assign pop         = advance && final_combo;
    assign combo_next  = final_combo ? '0 : combo_reg + 1'b1;

    always_comb
    begin
        logic [MOM_W-1:0] cross_ab;
        logic [MOM_W-1:0] cross_ba;
        logic [MOM_W-1:0] raw;
        pair     = PAIR_TABLE[combo_reg];
        ea       = head.wp[pair.a];
        eb       = head.wp[pair.b];
        cross_ab = umin(ea.leader_momentum, eb.runner_momentum);
        cross_ba = umin(ea.runner_momentum, eb.leader_momentum);
        if (combo_reg < COMBO_W'(NUM_WP))
        begin
            raw = (ea.pass_tally != TALLY_NONE) ? ea.leader_momentum : '0;
        end
        else if ((ea.pass_tally == TALLY_NONE) || (eb.pass_tally == TALLY_NONE))
        begin
            raw = '0;
        end
        else if (ea.leader_jet != eb.leader_jet)
        begin
            raw = umin(ea.leader_momentum, eb.leader_momentum);
        end
        else if ((ea.pass_tally == TALLY_ONE) && (eb.pass_tally == TALLY_ONE))
        begin
            // one jet leads both and nothing else passed
            raw = '0;
        end
        else if (ea.pass_tally == TALLY_ONE)
        begin
            raw = cross_ab;
        end
        else if (eb.pass_tally == TALLY_ONE)
        begin
            raw = cross_ba;
        end
        else
        begin
            raw = (cross_ab > cross_ba) ? cross_ab : cross_ba;
        end
        value = umin(raw, ceiling);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combo_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= queue_status.head_valid;
            if (advance)
            begin
                combo_reg <= combo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_combo_reg <= combo_reg;
            out_mom_reg   <= value;
            out_last_reg  <= final_combo;
        end
    end

endmodule

### src/tagged_jet_pair_pt_select_top.sv
// the ending item queues the summary; results then leave via the output register
// throughput: one jet per cycle unless stalled; 27 results per event, one per ready cycle
// the event queue holds two finished events; jets stall only when both slots wait
// reset: registers return to their defaults, event state and queue are cleared
// reset is asynchronous and active low
module tagged_jet_pair_pt_select_top
    import tjps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tjps_jet_if.sink              jets,
    tjps_result_if.source         results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cut_arr_t             cut_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [MOM_W-1:0]     ceiling_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic                 push;
    logic                 pop;
    event_summary_t       summary;
    event_summary_t       head;
    queue_status_t        queue_status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WP; i++)
            begin
                cut_reg[i] <= CUT_RESET[i];
            end
            limit_reg   <= LIMIT_RESET;
            ceiling_reg <= CEILING_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RAPIDITY_LIM: limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_MOM_CEILING:  ceiling_reg <= pwdata[MOM_W-1:0];
                default:          cut_reg[reg_idx] <= cut_t'(pwdata[SCORE_W-1:0]);
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RAPIDITY_LIM: prdata = APB_DATA_W'(limit_reg);
            REG_MOM_CEILING:  prdata = APB_DATA_W'(ceiling_reg);
            default:          prdata = APB_DATA_W'(cut_reg[reg_idx]);
        endcase
    end

    tjps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .jets         (jets),
        .cuts         (cut_reg),
        .limit        (limit_reg),
        .queue_status (queue_status),
        .push         (push),
        .summary      (summary)
    );

    tjps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (summary),
        .pop       (pop),
        .head      (head),
        .status    (queue_status)
    );

    tjps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_status (queue_status),
        .ceiling      (ceiling_reg),
        .pop          (pop),
        .results      (results)
    );

endmodule
